// ===== rtl/pressure_sensor_compensation_top_defines.svh =====
// assertion macros for the pressure compensation top level
`ifndef PRESSURE_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`define PRESSURE_SENSOR_COMPENSATION_TOP_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define PSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psc: implication check failed");

// next-cycle implication
`define PSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psc: next-cycle check failed");

`endif

// ===== rtl/psc_pkg.sv =====
// shared types and constants for the pressure compensation block
`default_nettype none

package psc_pkg;

  localparam int unsigned RAW_W     = 24;
  localparam int unsigned CAL_W     = 16;
  localparam int unsigned DT_W      = 25;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned QDEPTH    = 2;

  localparam int TEMP_REF   = 2000;
  localparam int TEMP_VCOLD = -1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } psc_reg_e;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } psc_cal_t;

  typedef struct packed {
    logic [RAW_W-1:0]       d1;
    logic signed [DT_W-1:0] dt;
    logic                   rv;
  } psc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } psc_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/psc_front.sv =====
// front stage: takes raw samples, computes dT and the reading-valid flag
`default_nettype none

module psc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [psc_pkg::RAW_W-1:0]   raw_pressure_i,
  input  logic [psc_pkg::RAW_W-1:0]   raw_temperature_i,
  input  logic [psc_pkg::CAL_W-1:0]   c5_i,
  input  psc_pkg::psc_qstat_t         qstat_i,
  output logic                        item_valid_o,
  output psc_pkg::psc_item_t          item_o
);
  import psc_pkg::*;

  logic      v_q, v_d;
  psc_item_t item_q, item_d;
  logic      push;
  logic      accept;

  assign push       = v_q && !qstat_i.full;
  assign in_ready_o = !v_q || push;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    v_d = v_q;
    if (accept) begin
      v_d = 1'b1;
    end else if (push) begin
      v_d = 1'b0;
    end
  end

  always_comb begin
    item_d.d1 = raw_pressure_i;
    // dT = D2 - C5 * 256, always fits the 25-bit signed range
    item_d.dt = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, c5_i, 8'b0});
    item_d.rv = (|raw_pressure_i) && (|raw_temperature_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = v_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ===== rtl/psc_queue.sv =====
// short queue between the front stage and the arithmetic pipeline
`default_nettype none

module psc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  psc_pkg::psc_item_t  item_i,
  input  logic                pop_i,
  output logic                item_valid_o,
  output psc_pkg::psc_item_t  item_o,
  output psc_pkg::psc_qstat_t stat_o
);
  import psc_pkg::*;

  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  psc_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_valid_o = !stat_o.empty;
  assign item_o       = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/psc_back.sv =====
// arithmetic pipeline: first-order terms, second-order bands, pressure and clamp
`default_nettype none

module psc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  input  psc_pkg::psc_item_t                item_i,
  output logic                              item_ready_o,
  input  psc_pkg::psc_cal_t                 cal_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [psc_pkg::OUT_W-1:0]  pressure_dmbar_o,
  output logic signed [psc_pkg::OUT_W-1:0]  temperature_cdeg_o,
  output logic                              reading_valid_o
);
  import psc_pkg::*;

  localparam int unsigned NSTG  = 10;
  localparam int unsigned PW    = CAL_W + 1 + DT_W;   // calibration word times dT
  localparam int unsigned SQW   = 2 * DT_W;           // dT squared, signed
  localparam int unsigned PDW   = SQW - 2;            // dT squared, magnitude
  localparam int unsigned TRW   = PDW + 2;            // 3 * dT^2
  localparam int unsigned DEVW  = 20;
  localparam int unsigned TIW   = TRW - 33;
  localparam int unsigned DSQW  = 2 * DEVW;
  localparam int unsigned DV2W  = 35;
  localparam int unsigned LW2W  = 36;
  localparam int unsigned IW    = LW2W + 3;
  localparam int unsigned SW    = IW + 1;
  localparam int unsigned SPLIT = SW / 2;
  localparam int unsigned PPL   = RAW_W + SPLIT;
  localparam int unsigned PPH   = RAW_W + 1 + (SW - SPLIT);
  localparam int unsigned PRW   = 64;
  localparam int unsigned Q1W   = PRW - 21;
  localparam int unsigned XW    = Q1W + 1;
  localparam int unsigned T2W   = DEVW + 1;

  localparam logic signed [XW-1:0] P_MAX = XW'(2147483647);
  localparam logic signed [XW-1:0] P_MIN = ~P_MAX;

  logic [NSTG-1:0] vld_q, vld_d;
  logic [NSTG-1:0] rv_q;
  logic            adv;

  // stage B: products with dT
  logic signed [PW-1:0]  p3_q, p4_q, p6_q, p3_d, p4_d, p6_d;
  logic signed [PW-1:0]  dt_x;
  logic signed [SQW-1:0] dt_sq;
  logic [PDW-1:0]        pdt_q;
  logic [RAW_W-1:0]      d1_q [5];

  // stage C: first-order terms
  logic signed [PW-1:0]   p3_b, p4_b, p6_b, p3_s, p4_s, p6_s;
  logic signed [SW-1:0]   sens1_d, off1_d;
  logic signed [SW-1:0]   sens1_q [1:3];
  logic signed [SW-1:0]   off1_q [1:3];
  logic signed [DEVW-1:0] dev_d, dev_q, low_d, low_q;
  logic [TRW-1:0]         tri3;
  logic [TIW-1:0]         ti_d, ti_q;

  // stage D: squares and band flags
  logic signed [DSQW-1:0] dev_sq, low_sq;
  logic [DV2W-1:0]        dev2_q;
  logic [LW2W-1:0]        low2_q;
  logic                   cold_q, vcold_q;
  logic signed [T2W-1:0]  t2_d;
  logic signed [T2W-1:0]  t2_q [2:9];

  // stage E: second-order corrections
  logic [IW-1:0] d3, d5, l7, l4, offi_d, sensi_d, offi_q, sensi_q;

  // stage F: corrected sensitivity and offset
  logic signed [SW-1:0] sens_d, sens_q, off_d;
  logic signed [SW-1:0] off_q [4:7];

  // stages G to K: D1 * SENS, scaling, clamp
  logic [PPL-1:0]          pp_lo_d, pp_lo_q;
  logic signed [PPH-1:0]   pp_hi_d, pp_hi_q;
  logic signed [PRW-1:0]   prod_d, prod_q, prb;
  logic signed [Q1W-1:0]   q1_d, q1_q;
  logic signed [XW-1:0]    x_d, x_q, xb, pf;
  logic [OUT_W-1:0]        pres_d, pres_q;

  assign adv          = !vld_q[NSTG-1] || out_ready_i;
  assign item_ready_o = adv;
  assign vld_d        = adv ? {vld_q[NSTG-2:0], item_valid_i} : vld_q;

  always_comb begin
    dt_x  = PW'(item_i.dt);
    p3_d  = PW'($signed({1'b0, cal_i.c3})) * dt_x;
    p4_d  = PW'($signed({1'b0, cal_i.c4})) * dt_x;
    p6_d  = PW'($signed({1'b0, cal_i.c6})) * dt_x;
    dt_sq = SQW'(item_i.dt) * SQW'(item_i.dt);
  end

  // divisions by powers of two truncate toward zero: bias negatives first
  always_comb begin
    p3_b    = p3_q + $signed({{(PW-8){1'b0}}, {8{p3_q[PW-1]}}});
    p4_b    = p4_q + $signed({{(PW-7){1'b0}}, {7{p4_q[PW-1]}}});
    p6_b    = p6_q + $signed({{(PW-23){1'b0}}, {23{p6_q[PW-1]}}});
    p3_s    = p3_b >>> 8;
    p4_s    = p4_b >>> 7;
    p6_s    = p6_b >>> 23;
    sens1_d = SW'(p3_s) + $signed(SW'({cal_i.c1, 15'b0}));
    off1_d  = SW'(p4_s) + $signed(SW'({cal_i.c2, 16'b0}));
    dev_d   = DEVW'(p6_s);
    low_d   = dev_d + DEVW'(TEMP_REF - TEMP_VCOLD);
    tri3    = TRW'({pdt_q, 1'b0}) + TRW'(pdt_q);
    ti_d    = dev_d[DEVW-1] ? tri3[TRW-1:33] : TIW'(pdt_q[PDW-1:36]);
  end

  always_comb begin
    dev_sq = DSQW'(dev_q) * DSQW'(dev_q);
    low_sq = DSQW'(low_q) * DSQW'(low_q);
    t2_d   = T2W'(dev_q) + T2W'(TEMP_REF) - $signed({{(T2W-TIW){1'b0}}, ti_q});
  end

  always_comb begin
    d3 = IW'({dev2_q, 1'b0}) + IW'(dev2_q);
    d5 = IW'({dev2_q, 2'b0}) + IW'(dev2_q);
    l7 = IW'({low2_q, 3'b0}) - IW'(low2_q);
    l4 = IW'({low2_q, 2'b0});
    if (cold_q) begin
      offi_d  = (d3 >> 1) + (vcold_q ? l7 : '0);
      sensi_d = (d5 >> 3) + (vcold_q ? l4 : '0);
    end else begin
      offi_d  = IW'(dev2_q >> 4);
      sensi_d = '0;
    end
  end

  always_comb begin
    sens_d  = sens1_q[3] - $signed({1'b0, sensi_q});
    off_d   = off1_q[3] - $signed({1'b0, offi_q});
    pp_lo_d = PPL'(d1_q[4]) * PPL'(sens_q[SPLIT-1:0]);
    pp_hi_d = PPH'($signed({1'b0, d1_q[4]})) * PPH'($signed(sens_q[SW-1:SPLIT]));
    prod_d  = $signed({pp_hi_q[PPH-2:0], {SPLIT{1'b0}}})
            + $signed({{(PRW-PPL){1'b0}}, pp_lo_q});
    prb     = prod_q + $signed({{(PRW-21){1'b0}}, {21{prod_q[PRW-1]}}});
    q1_d    = Q1W'(prb >>> 21);
    x_d     = XW'(q1_q) - XW'(off_q[7]);
    xb      = x_q + $signed({{(XW-13){1'b0}}, {13{x_q[XW-1]}}});
    pf      = xb >>> 13;
    if (pf > P_MAX) begin
      pres_d = P_MAX[OUT_W-1:0];
    end else if (pf < P_MIN) begin
      pres_d = P_MIN[OUT_W-1:0];
    end else begin
      pres_d = pf[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rv_q <= {rv_q[NSTG-2:0], item_i.rv};
      // stage B
      p3_q     <= p3_d;
      p4_q     <= p4_d;
      p6_q     <= p6_d;
      pdt_q    <= dt_sq[PDW-1:0];
      d1_q[0]  <= item_i.d1;
      // stage C
      sens1_q[1] <= sens1_d;
      off1_q[1]  <= off1_d;
      dev_q      <= dev_d;
      low_q      <= low_d;
      ti_q       <= ti_d;
      d1_q[1]    <= d1_q[0];
      // stage D
      dev2_q     <= dev_sq[DV2W-1:0];
      low2_q     <= low_sq[LW2W-1:0];
      cold_q     <= dev_q[DEVW-1];
      vcold_q    <= low_q[DEVW-1];
      t2_q[2]    <= t2_d;
      sens1_q[2] <= sens1_q[1];
      off1_q[2]  <= off1_q[1];
      d1_q[2]    <= d1_q[1];
      // stage E
      offi_q     <= offi_d;
      sensi_q    <= sensi_d;
      t2_q[3]    <= t2_q[2];
      sens1_q[3] <= sens1_q[2];
      off1_q[3]  <= off1_q[2];
      d1_q[3]    <= d1_q[2];
      // stage F
      sens_q   <= sens_d;
      off_q[4] <= off_d;
      t2_q[4]  <= t2_q[3];
      d1_q[4]  <= d1_q[3];
      // stage G
      pp_lo_q  <= pp_lo_d;
      pp_hi_q  <= pp_hi_d;
      off_q[5] <= off_q[4];
      t2_q[5]  <= t2_q[4];
      // stage H
      prod_q   <= prod_d;
      off_q[6] <= off_q[5];
      t2_q[6]  <= t2_q[5];
      // stage I
      q1_q     <= q1_d;
      off_q[7] <= off_q[6];
      t2_q[7]  <= t2_q[6];
      // stage J
      x_q      <= x_d;
      t2_q[8]  <= t2_q[7];
      // stage K, output register
      pres_q   <= pres_d;
      t2_q[9]  <= t2_q[8];
    end
  end

  assign out_valid_o        = vld_q[NSTG-1];
  assign pressure_dmbar_o   = $signed(pres_q);
  assign temperature_cdeg_o = OUT_W'(t2_q[9]);
  assign reading_valid_o    = rv_q[NSTG-1];

endmodule

`default_nettype wire

// ===== rtl/pressure_sensor_compensation_top.sv =====
// Pressure sensor compensation with second-order temperature correction. A raw
// pressure/temperature pair is taken as one transaction and one result comes
// back per transaction, in order: pressure in 0.1 mbar and temperature in
// 0.01 degC (signed 32 bits each, only pressure saturated), plus a flag that
// is set when both raw values are nonzero. The block accepts one transaction
// per clock while the output handshake does not stall; every stage of the
// 10-stage arithmetic pipeline is registered, so throughput is limited only
// by the output handshake. The front register, the queue and the pipeline
// lie between input and output. The calibration words C1..C6 are registers
// 0..5 of the write port; indexes past 5 are ignored, and they may be changed
// only while no transaction is in flight.
`default_nettype none

module pressure_sensor_compensation_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [psc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [psc_pkg::CAL_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [psc_pkg::RAW_W-1:0]         raw_pressure_i,
  input  logic [psc_pkg::RAW_W-1:0]         raw_temperature_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [psc_pkg::OUT_W-1:0]  pressure_dmbar_o,
  output logic signed [psc_pkg::OUT_W-1:0]  temperature_cdeg_o,
  output logic                              reading_valid_o
);
  import psc_pkg::*;
  `include "pressure_sensor_compensation_top_defines.svh"

  psc_cal_t   cal_q, cal_d;
  logic       front_valid;
  psc_item_t  front_item;
  psc_qstat_t q_stat;
  logic       q_push;
  logic       q_valid;
  psc_item_t  q_item;
  logic       back_ready;
  logic       q_pop;

  always_comb begin
    cal_d = cal_q;
    if (cfg_we_i) begin
      case (psc_reg_e'(cfg_index_i))
        REG_C1:  cal_d.c1 = cfg_data_i;
        REG_C2:  cal_d.c2 = cfg_data_i;
        REG_C3:  cal_d.c3 = cfg_data_i;
        REG_C4:  cal_d.c4 = cfg_data_i;
        REG_C5:  cal_d.c5 = cfg_data_i;
        REG_C6:  cal_d.c6 = cfg_data_i;
        default: cal_d = cal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  psc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .c5_i              (cal_q.c5),
    .qstat_i           (q_stat),
    .item_valid_o      (front_valid),
    .item_o            (front_item)
  );

  assign q_push = front_valid && !q_stat.full;
  assign q_pop  = q_valid && back_ready;

  psc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .item_i       (front_item),
    .pop_i        (q_pop),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .stat_o       (q_stat)
  );

  psc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_valid_i       (q_valid),
    .item_i             (q_item),
    .item_ready_o       (back_ready),
    .cal_i              (cal_q),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .pressure_dmbar_o   (pressure_dmbar_o),
    .temperature_cdeg_o (temperature_cdeg_o),
    .reading_valid_o    (reading_valid_o)
  );

  `PSC_ASSERT_IMP(a_queue_status, q_stat.full, !q_stat.empty)
  `PSC_ASSERT_IMP(a_stall_blocks_pop, out_valid_o && !out_ready_i, !q_pop)
  `PSC_ASSERT_NEXT(a_full_queue_loads_front, in_valid_i && in_ready_o && q_stat.full, front_valid)

endmodule

`default_nettype wire

// ===== bench/tb_pressure_sensor_compensation_top.sv =====
// self-checking testbench for the pressure sensor compensation block
module tb_pressure_sensor_compensation_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psc_pkg::*;

  localparam int unsigned PIPE_LATENCY = 12;
  localparam int unsigned SETTLE       = 3 * PIPE_LATENCY;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned NUM_PHASES   = 9;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned MAX_REPORTS  = 30;

  // indexes beyond the calibration words, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [OUT_W-1:0] pressure;
    logic signed [OUT_W-1:0] temperature;
    logic                    valid;
  } reading_t;

  class reading_board;
    psc_cal_t    cal;
    reading_t    awaited[$];
    int unsigned errors;

    function new();
      cal    = '0;
      errors = 0;
    endfunction

    function void write_word(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] word);
      case (idx)
        REG_C1: cal.c1 = word;
        REG_C2: cal.c2 = word;
        REG_C3: cal.c3 = word;
        REG_C4: cal.c4 = word;
        REG_C5: cal.c5 = word;
        REG_C6: cal.c6 = word;
        default: ;
      endcase
    endfunction

    function logic signed [OUT_W-1:0] saturate(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[OUT_W-1:0];
    endfunction

    // first-order terms, then the three-band second-order correction
    function reading_t compensate(logic [RAW_W-1:0] d1_raw, logic [RAW_W-1:0] d2_raw);
      longint   d1, d2, c1, c2, c3, c4, c5, c6;
      longint   dt, sens, off, temp, dev, ti, offi, sensi, cold, p;
      reading_t r;
      d1 = d1_raw;
      d2 = d2_raw;
      c1 = cal.c1;
      c2 = cal.c2;
      c3 = cal.c3;
      c4 = cal.c4;
      c5 = cal.c5;
      c6 = cal.c6;
      dt   = d2 - c5 * 256;
      sens = c1 * 32768 + (c3 * dt) / 256;
      off  = c2 * 65536 + (c4 * dt) / 128;
      temp = TEMP_REF + (dt * c6) / 8388608;
      dev  = temp - TEMP_REF;
      if (temp < TEMP_REF) begin
        ti    = (3 * dt * dt) / 64'sd8589934592;
        offi  = (3 * dev * dev) / 2;
        sensi = (5 * dev * dev) / 8;
        if (temp < TEMP_VCOLD) begin
          cold  = temp - TEMP_VCOLD;
          offi  = offi + 7 * cold * cold;
          sensi = sensi + 4 * cold * cold;
        end
      end else begin
        ti    = (2 * dt * dt) / 64'sd137438953472;
        offi  = (dev * dev) / 16;
        sensi = 0;
      end
      off  = off - offi;
      sens = sens - sensi;
      p    = ((d1 * sens) / 2097152 - off) / 8192;
      r.pressure    = saturate(p);
      r.temperature = saturate(temp - ti);
      r.valid       = (d1_raw != 0) && (d2_raw != 0);
      return r;
    endfunction

    function void note_pair(logic [RAW_W-1:0] d1_raw, logic [RAW_W-1:0] d2_raw);
      awaited.push_back(compensate(d1_raw, d2_raw));
    endfunction

    function void complain(string field, longint want, longint got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_reading(logic signed [OUT_W-1:0] p, logic signed [OUT_W-1:0] t,
                                logic v);
      reading_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result expected none actual p=%0d t=%0d v=%0b",
                   $time, p, t, v);
        return;
      end
      want = awaited.pop_front();
      if (p !== want.pressure) complain("pressure_dmbar", want.pressure, p);
      if (t !== want.temperature) complain("temperature_cdeg", want.temperature, t);
      if (v !== want.valid) complain("reading_valid", want.valid, v);
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CAL_W-1:0]        cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [RAW_W-1:0]        raw_pressure_i;
  logic [RAW_W-1:0]        raw_temperature_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [OUT_W-1:0] pressure_dmbar_o;
  logic signed [OUT_W-1:0] temperature_cdeg_o;
  logic                    reading_valid_o;

  reading_board board = new();
  bit           no_idle = 1'b0;

  pressure_sensor_compensation_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pressure_dmbar_o  (pressure_dmbar_o),
    .temperature_cdeg_o(temperature_cdeg_o),
    .reading_valid_o   (reading_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_pair(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    in_valid_i        <= 1'b1;
    raw_pressure_i    <= d1;
    raw_temperature_i <= d2;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_pair(d1, d2);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic put_word(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] word);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    @(posedge clk_i);
    board.write_word(idx, word);
  endtask

  task automatic load_cal(input psc_cal_t words, input bit with_spare);
    put_word(REG_C1, words.c1);
    put_word(REG_C2, words.c2);
    put_word(REG_C3, words.c3);
    put_word(REG_C4, words.c4);
    put_word(REG_C5, words.c5);
    put_word(REG_C6, words.c6);
    if (with_spare) begin
      put_word(IDX_SPARE_LO, CAL_W'($urandom));
      put_word(IDX_SPARE_HI, CAL_W'($urandom));
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CAL_W-1:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CAL_W'($urandom);
    endcase
  endfunction

  // output side: ready drops in bursts, except in the final phase
  initial begin : result_sink
    forever begin
      if (no_idle) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_reading(pressure_dmbar_o, temperature_cdeg_o, reading_valid_o);
  end

  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck = 0;
      else stuck++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    psc_cal_t         words;
    logic [RAW_W-1:0] d1, d2;
    int               near;
    int unsigned      gap_odds;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    raw_pressure_i    = '0;
    raw_temperature_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // calibration words still at their reset value of zero
    send_pair(24'h000000, 24'h000000);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'h000001, 24'h000000);
    send_pair(24'h800000, 24'h800000);
    wait_drained();

    // typical calibration: reference point sits at d2 = 6821376
    words = '{c1: 16'd34982, c2: 16'd36352, c3: 16'd20328,
              c4: 16'd22354, c5: 16'd26646, c6: 16'd26146};
    load_cal(words, 1'b1);
    send_pair(24'd4311550, 24'd8077636);
    send_pair(24'd4311550, 24'd6821376);
    send_pair(24'd4311550, 24'd6821055);
    send_pair(24'd4311550, 24'd6821056);
    send_pair(24'd4311550, 24'd5698445);
    send_pair(24'd4311550, 24'd5698125);
    send_pair(24'd0, 24'd8077636);
    send_pair(24'd4311550, 24'd0);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'd1, 24'd1);
    send_pair(24'hFFFFFF, 24'h000000);
    send_pair(24'h000000, 24'h000000);
    wait_drained();

    words = '1;
    load_cal(words, 1'b0);
    send_pair(24'hFFFFFF, 24'h000000);
    send_pair(24'h000000, 24'hFFFFFF);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'h123456, 24'h000001);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      words = {pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
      case (phase)
        1: words = '1;
        2: begin  // deepest cold band
          words.c5 = '1;
          words.c6 = '1;
        end
        3: begin  // hottest corner
          words.c5 = '0;
          words.c6 = '1;
        end
        4: words = '0;
        default: ;
      endcase
      load_cal(words, phase[0]);
      no_idle = (phase == NUM_PHASES - 1);
      case ($urandom_range(0, 3))
        0:       gap_odds = 0;
        1:       gap_odds = 3;
        2:       gap_odds = 8;
        default: gap_odds = 20;
      endcase
      if (no_idle) gap_odds = 0;
      repeat (PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0:       d1 = '0;
          1:       d1 = '1;
          2:       d1 = RAW_W'($urandom_range(1, 255));
          default: d1 = RAW_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0: d2 = '0;
          1: d2 = '1;
          2, 3, 4: begin
            // around the reference point, where the temperature bands split
            near = int'(board.cal.c5) * 256 + int'($urandom_range(0, 1 << 21)) - (1 << 20);
            if (near < 0) near = 0;
            if (near > 24'hFFFFFF) near = 24'hFFFFFF;
            d2 = near[RAW_W-1:0];
          end
          default: d2 = RAW_W'($urandom);
        endcase
        send_pair(d1, d2);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk_i);
        end
      end
    end

    wait_drained();
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/psc_pkg.sv
rtl/psc_front.sv
rtl/psc_queue.sv
rtl/psc_back.sv
rtl/pressure_sensor_compensation_top.sv
bench/tb_pressure_sensor_compensation_top.sv
